// ===== src/chd_pkg.sv =====
// Shared constants, types and helpers for the cumulative depth histogram core.
package chd_pkg;

    localparam int DEPTH_BINS = 16384;
    localparam int BIN_AW     = $clog2(DEPTH_BINS);
    localparam int CNT_W      = 21;
    localparam int ACT_W      = 15;
    localparam int DEPTH_W    = 16;
    localparam int INT_W      = 9;
    localparam int STEP_W     = $clog2(INT_W);

    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [ACT_W-1:0]  ACT_RESET  = ACT_W'(10000);
    localparam logic [ACT_W-1:0]  BINS_LIMIT = ACT_W'(DEPTH_BINS);
    localparam logic [BIN_AW-1:0] BIN_LAST   = BIN_AW'(DEPTH_BINS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(INT_W - 1);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_FINAL = 2'd2,
        CMD_QUERY = 2'd3
    } chd_cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_ADD,
        ST_FIN_LOAD,
        ST_FIN,
        ST_QRD,
        ST_QDIV
    } chd_state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } chd_div_req_t;

    typedef struct packed {
        logic             done;
        logic [INT_W-1:0] quot;
    } chd_div_rsp_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ===== src/cumulative_depth_histogram_core.sv =====
// Top level of the cumulative depth histogram core: command sequencer around the bin memory.
// A command is taken when start is high and busy is low; its single result appears on
// intensity and status for exactly one cycle with done high and must be captured then.
// After reset the core sweeps all 16384 bins to zero, holding busy high until the sweep
// ends (configuration writes are still taken). Steps per command, from accept to done:
// clear writes one bin per cycle through the memory's write port; add of an in-range
// nonzero depth reads the bin in the accept cycle and writes it back with done;
// finalize runs over the first min(active_bins, 16384) bins, one bin per cycle, with the
// running sum held in a register; query of an in-range nonzero depth does a memory read,
// a compare and nine divider steps, skipping the divider when the bin value is at or
// above the point count; commands that need no memory access (depth zero, depth out of
// range, empty histogram, finalize with fewer than two bins) answer from the idle state
// and never raise busy. A command that raises busy releases it together with done, so
// the next command is taken at the earliest at the edge that ends the done cycle.
module cumulative_depth_histogram_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [chd_pkg::DEPTH_W-1:0]   depth,
    output logic                          done,
    output logic [chd_pkg::INT_W-1:0]     intensity,
    output logic                          status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [chd_pkg::ACT_W-1:0]     cfg_data
);

    chd_pkg::chd_state_t           state_reg, state_next;
    logic [chd_pkg::BIN_AW-1:0]    cnt_reg, cnt_next;
    logic [chd_pkg::BIN_AW-1:0]    widx_reg, widx_next;
    logic [chd_pkg::BIN_AW-1:0]    d_reg, d_next;
    logic [chd_pkg::ACT_W-1:0]     lim_reg, lim_next;
    logic [chd_pkg::ACT_W-1:0]     active_reg, active_next;
    logic [chd_pkg::CNT_W-1:0]     pt_reg, pt_next;
    logic [chd_pkg::CNT_W-1:0]     run_reg, run_next;
    logic                          done_reg, done_next;
    logic [chd_pkg::INT_W-1:0]     intensity_reg, intensity_next;
    logic                          status_reg, status_next;

    logic                          ram_we;
    logic [chd_pkg::BIN_AW-1:0]    ram_waddr;
    logic [chd_pkg::CNT_W-1:0]     ram_wdata;
    logic [chd_pkg::BIN_AW-1:0]    ram_raddr;
    logic [chd_pkg::CNT_W-1:0]     ram_rdata;

    chd_pkg::chd_div_req_t         div_req;
    chd_pkg::chd_div_rsp_t         div_rsp;

    logic [chd_pkg::ACT_W-1:0]     eff;
    logic                          depth_oob;
    logic [chd_pkg::CNT_W-1:0]     fin_sum;

    chd_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    chd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign eff       = (active_reg > chd_pkg::BINS_LIMIT) ? chd_pkg::BINS_LIMIT : active_reg;
    assign depth_oob = (depth >= {1'b0, eff});
    assign fin_sum   = chd_pkg::sat_add(ram_rdata, run_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chd_pkg::ST_INIT;
            cnt_reg    <= '0;
            active_reg <= chd_pkg::ACT_RESET;
            pt_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            pt_reg     <= pt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg      <= widx_next;
        d_reg         <= d_next;
        lim_reg       <= lim_next;
        run_reg       <= run_next;
        intensity_reg <= intensity_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        widx_next        = widx_reg;
        d_next           = d_reg;
        lim_next         = lim_reg;
        pt_next          = pt_reg;
        run_next         = run_reg;
        done_next        = 1'b0;
        intensity_next   = intensity_reg;
        status_next      = status_reg;
        active_next      = (cfg_valid && cfg_ready) ? cfg_data : active_reg;
        ram_we           = 1'b0;
        ram_waddr        = cnt_reg;
        ram_wdata        = '0;
        ram_raddr        = depth[chd_pkg::BIN_AW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = pt_reg - ram_rdata;
        div_req.divisor  = pt_reg;
        unique case (state_reg)
            chd_pkg::ST_INIT:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == chd_pkg::BIN_LAST)
                begin
                    state_next = chd_pkg::ST_IDLE;
                end
            end
            chd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    d_next         = depth[chd_pkg::BIN_AW-1:0];
                    intensity_next = '0;
                    status_next    = 1'b0;
                    unique case (chd_pkg::chd_cmd_t'(command))
                        chd_pkg::CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = chd_pkg::ST_CLEAR;
                        end
                        chd_pkg::CMD_ADD:
                        begin
                            if (depth == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (depth_oob)
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = chd_pkg::ST_ADD;
                            end
                        end
                        chd_pkg::CMD_FINAL:
                        begin
                            ram_raddr = '0;
                            lim_next  = eff;
                            cnt_next  = chd_pkg::BIN_AW'(1);
                            if (eff >= chd_pkg::ACT_W'(2))
                            begin
                                state_next = chd_pkg::ST_FIN_LOAD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        chd_pkg::CMD_QUERY:
                        begin
                            if (depth == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (depth_oob)
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                            else if (pt_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = chd_pkg::ST_QRD;
                            end
                        end
                        default:
                        begin
                            state_next = chd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            chd_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == chd_pkg::BIN_LAST)
                begin
                    pt_next    = '0;
                    done_next  = 1'b1;
                    state_next = chd_pkg::ST_IDLE;
                end
            end
            chd_pkg::ST_ADD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = d_reg;
                ram_wdata  = chd_pkg::sat_add(ram_rdata, chd_pkg::CNT_W'(1));
                pt_next    = chd_pkg::sat_add(pt_reg, chd_pkg::CNT_W'(1));
                done_next  = 1'b1;
                state_next = chd_pkg::ST_IDLE;
            end
            chd_pkg::ST_FIN_LOAD:
            begin
                run_next   = ram_rdata;
                ram_raddr  = cnt_reg;
                widx_next  = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = chd_pkg::ST_FIN;
            end
            chd_pkg::ST_FIN:
            begin
                ram_we    = 1'b1;
                ram_waddr = widx_reg;
                ram_wdata = fin_sum;
                run_next  = fin_sum;
                if ({1'b0, widx_reg} == (lim_reg - 1'b1))
                begin
                    done_next  = 1'b1;
                    state_next = chd_pkg::ST_IDLE;
                end
                else
                begin
                    ram_raddr = cnt_reg;
                    widx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            chd_pkg::ST_QRD:
            begin
                if (ram_rdata >= pt_reg)
                begin
                    done_next  = 1'b1;
                    state_next = chd_pkg::ST_IDLE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = chd_pkg::ST_QDIV;
                end
            end
            chd_pkg::ST_QDIV:
            begin
                if (div_rsp.done)
                begin
                    intensity_next = div_rsp.quot;
                    done_next      = 1'b1;
                    state_next     = chd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != chd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign intensity = intensity_reg;
    assign status    = status_reg;

endmodule

// ===== src/chd_ram.sv =====
// Bin count memory: one write port, one read port with registered read data.
module chd_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [chd_pkg::BIN_AW-1:0]    waddr,
    input  logic [chd_pkg::CNT_W-1:0]     wdata,
    input  logic [chd_pkg::BIN_AW-1:0]    raddr,
    output logic [chd_pkg::CNT_W-1:0]     rdata
);

    logic [chd_pkg::CNT_W-1:0] mem [chd_pkg::DEPTH_BINS];
    logic [chd_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/chd_div.sv =====
// Restoring divider producing floor(256 * dividend / divisor), one quotient bit per cycle.
module chd_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  chd_pkg::chd_div_req_t req,
    output chd_pkg::chd_div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [chd_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [chd_pkg::CNT_W:0]           rem_reg, rem_next;
    logic [chd_pkg::CNT_W-1:0]         den_reg, den_next;
    logic [chd_pkg::INT_W-1:0]         quot_reg, quot_next;
    logic [chd_pkg::CNT_W:0]           trial;
    logic                              qbit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        trial     = (step_reg == '0) ? rem_reg : {rem_reg[chd_pkg::CNT_W-1:0], 1'b0};
        qbit      = (trial >= {1'b0, den_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, req.dividend};
            den_next  = req.divisor;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? (trial - {1'b0, den_reg}) : trial;
            quot_next = {quot_reg[chd_pkg::INT_W-2:0], qbit};
            if (step_reg == chd_pkg::STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== src/chd_checker.sv =====
// Port-level checks for the cumulative depth histogram core, bound to the top level.
module chd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [chd_pkg::INT_W-1:0] intensity,
    input logic                      status
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a command");

    a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (intensity <= chd_pkg::INT_W'(256)))
        else $error("intensity above 256");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (intensity == '0))
        else $error("rejected depth with nonzero intensity");

endmodule

bind cumulative_depth_histogram_core chd_checker u_chd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .intensity (intensity),
    .status    (status)
);

// ===== tb/sv/cumulative_depth_histogram_core_test.sv =====
// Self-checking testbench for the cumulative depth histogram core.
module cumulative_depth_histogram_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import chd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic             status;
    } reply_t;

    typedef struct packed {
        chd_cmd_t           cmd;
        logic [DEPTH_W-1:0] depth;
        logic               known;
        logic [INT_W-1:0]   intensity;
        logic               status;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic [DEPTH_W-1:0] depth;
    logic               done;
    logic [INT_W-1:0]   intensity;
    logic               status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ACT_W-1:0]   cfg_data;

    logic [CNT_W-1:0]   hist_bins [DEPTH_BINS];
    logic [CNT_W-1:0]   hist_points;
    logic [ACT_W-1:0]   bin_limit;

    reply_t             awaited_replies [$];
    int                 error_count;
    int                 checked_count;
    int                 flagged_count;
    int                 lit_count;
    int                 setting_count;
    int                 cmd_count [4];
    bit                 steady;

    stim_row_t directed_rows [25] = '{
        '{CMD_QUERY, 16'd5,     1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd0,     1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'hFFFF,  1'b1, 9'd0,   1'b1},
        '{CMD_FINAL, 16'd0,     1'b1, 9'd0,   1'b0},
        '{CMD_ADD,   16'd0,     1'b1, 9'd0,   1'b0},
        '{CMD_ADD,   16'd10000, 1'b1, 9'd0,   1'b1},
        '{CMD_ADD,   16'hFFFF,  1'b1, 9'd0,   1'b1},
        '{CMD_ADD,   16'd9999,  1'b1, 9'd0,   1'b0},
        '{CMD_ADD,   16'd1,     1'b1, 9'd0,   1'b0},
        '{CMD_ADD,   16'd1,     1'b1, 9'd0,   1'b0},
        '{CMD_ADD,   16'd5,     1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd2,     1'b1, 9'd256, 1'b0},
        '{CMD_QUERY, 16'd1,     1'b0, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd9999,  1'b0, 9'd0,   1'b0},
        '{CMD_FINAL, 16'd0,     1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd1,     1'b0, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd5,     1'b0, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd9999,  1'b0, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd10000, 1'b1, 9'd0,   1'b1},
        '{CMD_FINAL, 16'hFFFF,  1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd4,     1'b0, 9'd0,   1'b0},
        '{CMD_ADD,   16'd16384, 1'b1, 9'd0,   1'b1},
        '{CMD_CLEAR, 16'hFFFF,  1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'd1,     1'b1, 9'd0,   1'b0},
        '{CMD_QUERY, 16'hAAAA,  1'b1, 9'd0,   1'b1}
    };

    cumulative_depth_histogram_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .depth     (depth),
        .done      (done),
        .intensity (intensity),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned usable_bins();
        return (bin_limit > DEPTH_BINS) ? DEPTH_BINS : bin_limit;
    endfunction

    function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        int unsigned s;
        s = a + b;
        return (s > CNT_MAX) ? CNT_MAX : CNT_W'(s);
    endfunction

    // Apply one command to the histogram and return the reply it should produce.
    function automatic reply_t histogram_step(input chd_cmd_t cmd,
                                              input logic [DEPTH_W-1:0] dep);
        reply_t          res;
        int unsigned     eff;
        int              k;
        longint unsigned n;
        longint unsigned c;
        res = '0;
        eff = usable_bins();
        case (cmd)
            CMD_CLEAR:
            begin
                for (k = 0; k < DEPTH_BINS; k++)
                    hist_bins[k] = '0;
                hist_points = '0;
            end
            CMD_ADD:
            begin
                if (dep != 0)
                begin
                    if (dep >= eff)
                        res.status = 1'b1;
                    else
                    begin
                        hist_bins[dep[BIN_AW-1:0]] = sat_sum(hist_bins[dep[BIN_AW-1:0]],
                                                             CNT_W'(1));
                        hist_points = sat_sum(hist_points, CNT_W'(1));
                    end
                end
            end
            CMD_FINAL:
            begin
                for (k = 1; k < eff; k++)
                    hist_bins[k] = sat_sum(hist_bins[k], hist_bins[k-1]);
            end
            default:
            begin
                if (dep != 0)
                begin
                    if (dep >= eff)
                        res.status = 1'b1;
                    else if (hist_points != 0)
                    begin
                        n = hist_points;
                        c = hist_bins[dep[BIN_AW-1:0]];
                        if (c < n)
                            res.intensity = INT_W'((256 * (n - c)) / n);
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Bias toward in-range depths with a hot low window; keep zero, edge and wild values.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int unsigned eff;
        int unsigned r;
        int unsigned top;
        eff = usable_bins();
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 14 || eff < 2)
            return DEPTH_W'($urandom);
        if (r < 20)
            return DEPTH_W'(eff + $urandom_range(0, 2));
        if (r < 25)
            return DEPTH_W'(eff - 1);
        top = (r < 60 && eff > 33) ? 32 : eff - 1;
        return DEPTH_W'($urandom_range(1, top));
    endfunction

    task automatic issue_command(input chd_cmd_t cmd, input logic [DEPTH_W-1:0] dep,
                                 input logic known, input logic [INT_W-1:0] lvl,
                                 input logic st);
        int     gap;
        reply_t want;
        if ($urandom_range(0, 31) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        depth   <= dep;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = histogram_step(cmd, dep);
        if (known)
            want = '{intensity: lvl, status: st};
        awaited_replies.push_back(want);
        cmd_count[int'(cmd)]++;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bin_limit(input logic [ACT_W-1:0] val);
        repeat ($urandom_range(0, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bin_limit = val;
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // Frames of clear, adds with stray queries, finalize passes, queries with stray adds.
    task automatic run_phase(input logic [ACT_W-1:0] limit, input int frames, input int adds,
                             input int queries, input int passes, input bit fresh);
        int f;
        int i;
        settle();
        write_bin_limit(limit);
        for (f = 0; f < frames; f++)
        begin
            if (fresh || f > 0)
                issue_command(CMD_CLEAR, DEPTH_W'($urandom), 1'b0, '0, 1'b0);
            for (i = 0; i < adds; i++)
                issue_command(($urandom_range(0, 9) == 0) ? CMD_QUERY : CMD_ADD,
                              pick_depth(), 1'b0, '0, 1'b0);
            for (i = 0; i < passes; i++)
                issue_command(CMD_FINAL, DEPTH_W'($urandom), 1'b0, '0, 1'b0);
            for (i = 0; i < queries; i++)
                issue_command(($urandom_range(0, 9) == 0) ? CMD_ADD : CMD_QUERY,
                              pick_depth(), 1'b0, '0, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected result: intensity %0d status %0d", intensity, status);
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                checked_count++;
                if (status)
                    flagged_count++;
                if (intensity != 0)
                    lit_count++;
                if (intensity !== want.intensity)
                begin
                    $error("intensity: expected %0d, got %0d", want.intensity, intensity);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int r;
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_CLEAR;
        depth     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        steady    = 1'b0;
        for (r = 0; r < DEPTH_BINS; r++)
            hist_bins[r] = '0;
        hist_points = '0;
        bin_limit   = ACT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < $size(directed_rows); r++)
            issue_command(directed_rows[r].cmd, directed_rows[r].depth, directed_rows[r].known,
                          directed_rows[r].intensity, directed_rows[r].status);

        run_phase(15'd2,                        2, 30,  20,  2, 1'b1);
        run_phase(BINS_LIMIT,                   1, 140, 100, 2, 1'b1);
        run_phase(15'h7FFF,                     1, 110, 80,  1, 1'b0);
        run_phase(15'd0,                        1, 30,  20,  1, 1'b0);
        run_phase(15'd1,                        1, 25,  15,  1, 1'b1);
        run_phase(ACT_W'($urandom_range(2, 64)),    2, 60, 40, 3, 1'b1);
        run_phase(ACT_W'($urandom_range(2, 600)),   2, 75, 50, 2, 1'b1);
        run_phase(ACT_W'($urandom_range(600, 16384)), 1, 110, 80, 1, 1'b1);
        run_phase(ACT_RESET,                    1, 90,  60,  1, 1'b0);

        settle();
        repeat (20) @(posedge clk);
        $display("Ran %0d clears, %0d adds, %0d finalizes and %0d queries over %0d bin settings.",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], setting_count);
        $display("Checked %0d results: %0d out-of-range flags, %0d nonzero intensities.",
                 checked_count, flagged_count, lit_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
